// ===== hw/rtl/lpp_pkg.sv =====
// Shared types, widths and codes for the LRU page pool directory.
// Used by lpp_control, lpp_datapath and lru_page_pool_with_pinning.
`default_nettype none

package lpp_pkg;

   localparam int POOL_FRAMES   = 16;
   localparam int PIN_SLOTS     = 8;
   localparam int FRAME_W       = $clog2(POOL_FRAMES);
   localparam int SLOT_W        = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
   localparam int PAGE_W        = 32;
   localparam int CNT_W         = 16;
   localparam int TOTAL_W       = 32;
   localparam int FUNC_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int FRAME_FIELD_W = 4;
   localparam int RSP_FIELDS_W  = FRAME_FIELD_W + 1 + PAGE_W + 1 + 3 * TOTAL_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [CNT_W-1:0] PIN_MAX = {CNT_W{1'b1}};

   localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIN   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UNPIN = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT       = 3'd0,
      ST_MISS      = 3'd1,
      ST_EXHAUSTED = 3'd2,
      ST_PIN_FULL  = 3'd3,
      ST_UNPIN_BAD = 3'd4,
      ST_PIN_DONE  = 3'd5
   } status_type;

   typedef struct packed {
      logic capture;
      logic look;
      logic apply;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_known;
   } dp_stat_type;

   function automatic logic [FRAME_W-1:0] lowest_frame(input logic [POOL_FRAMES-1:0] v);
      logic [FRAME_W-1:0] idx;
      idx = '0;
      for (int i = POOL_FRAMES - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = FRAME_W'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [SLOT_W-1:0] lowest_slot(input logic [PIN_SLOTS-1:0] v);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = PIN_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lru_page_pool_with_pinning.sv =====
// Top level of the LRU page pool directory with pin counts.
// Instantiates lpp_control and lpp_datapath; types from lpp_pkg.
//
//   channel  dir  handshake            tuser          tdata
//   req_     in   req_tvalid/tready    func [1:0]     page [31:0]
//   rsp_     out  rsp_tvalid/tready    status [2:0]   frame, evicted, evicted_page,
//                                                     pinned_now, hit/miss/evict totals
//
// Each item passes through a lookup cycle, which registers the tag, free and pin
// compares, and an apply cycle, which updates ranks, pins and counters into the
// result register. The next beat is taken in the apply cycle.
// Apply waits while the result register holds a beat that is not taken.
// Synchronous reset clears valid bits, ranks, pin table and counters.
// A request with func 3 is taken and dropped with no result.
`default_nettype none

module lru_page_pool_with_pinning (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [lpp_pkg::FUNC_W-1:0]         req_tuser,  // func
   input  wire logic [lpp_pkg::PAGE_W-1:0]         req_tdata,  // page
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [lpp_pkg::STATUS_W-1:0]            rsp_tuser,  // status
   // frame[3:0], evicted[4], evicted_page[36:5], pinned_now[37],
   // hit_total[69:38], miss_total[101:70], evict_total[133:102], zero pad
   output logic [lpp_pkg::RSP_DATA_W-1:0]          rsp_tdata
);

   lpp_pkg::ctl_cmd_type cmd;
   lpp_pkg::dp_stat_type stat;

   lpp_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lpp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_func   (req_tuser),
      .req_page   (req_tdata),
      .rsp_status (rsp_tuser),
      .rsp_data   (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/lpp_control.sv =====
// Sequencer for the page pool directory: accept, look up, apply, hold result.
// Depends on lpp_pkg for the command and status structs.
`default_nettype none

module lpp_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire lpp_pkg::dp_stat_type stat,
   output lpp_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_LOOK  = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_apply;
   logic      take;

   assign can_apply  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !reset &&
                       ((state_ff == S_IDLE) || ((state_ff == S_APPLY) && can_apply));
   assign take       = req_tvalid && req_tready && stat.req_known;

   assign cmd.capture = take;
   assign cmd.look    = (state_ff == S_LOOK);
   assign cmd.apply   = (state_ff == S_APPLY) && can_apply;
   assign rsp_tvalid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (can_apply) begin
               state_in = take ? S_LOOK : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lpp_datapath.sv =====
// Frame directory, recency ranks, pin table and counters of the page pool.
// Depends on lpp_pkg; driven by lpp_control through ctl_cmd_type.
`default_nettype none

module lpp_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lpp_pkg::ctl_cmd_type                cmd,
   output lpp_pkg::dp_stat_type                     stat,
   input  wire logic [lpp_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [lpp_pkg::PAGE_W-1:0]          req_page,
   output logic [lpp_pkg::STATUS_W-1:0]             rsp_status,
   output logic [lpp_pkg::RSP_DATA_W-1:0]           rsp_data
);

   localparam int NF = lpp_pkg::POOL_FRAMES;
   localparam int NS = lpp_pkg::PIN_SLOTS;
   localparam int FW = lpp_pkg::FRAME_W;
   localparam int SW = lpp_pkg::SLOT_W;
   localparam int PW = lpp_pkg::PAGE_W;
   localparam int CW = lpp_pkg::CNT_W;
   localparam int TW = lpp_pkg::TOTAL_W;

   // request
   logic [lpp_pkg::FUNC_W-1:0] func_ff;
   logic [PW-1:0]              page_ff;

   // directory state
   logic [NF-1:0] frame_valid_ff, frame_valid_in;
   logic [PW-1:0] frame_page_ff [NF];
   logic [FW-1:0] rank_ff [NF];
   logic [FW-1:0] rank_in [NF];
   logic [NS-1:0] pin_used_ff, pin_used_in;
   logic [PW-1:0] pin_page_ff [NS];
   logic [CW-1:0] pin_count_ff [NS];
   logic [CW-1:0] pin_count_in [NS];
   logic [TW-1:0] hits_ff, hits_in, misses_ff, misses_in, evicts_ff, evicts_in;

   // lookup results
   logic [NF-1:0] hit_vec_ff, hit_vec_in;
   logic [NF-1:0] free_vec_ff, free_vec_in;
   logic [NF-1:0] pinned_vec_ff, pinned_vec_in;
   logic [NS-1:0] match_vec_ff, match_vec_in;
   logic [NS-1:0] open_vec_ff, open_vec_in;
   logic [NF-1:0] victim_vec;

   logic [FW-1:0] hit_idx, free_idx, victim_idx;
   logic [SW-1:0] match_idx, open_idx;

   // write ports of the page arrays
   logic          fp_we;
   logic [FW-1:0] fp_idx;
   logic          pp_we;
   logic [SW-1:0] pp_idx;

   // promotion
   logic          promote_en;
   logic          promote_all;
   logic [FW-1:0] promote_idx;
   logic [FW-1:0] promote_limit;

   // result beat
   lpp_pkg::status_type status_ff, status_in;
   logic [FW-1:0] frame_ff, frame_in;
   logic          evicted_ff, evicted_in;
   logic [PW-1:0] ev_page_ff, ev_page_in;
   logic          pinned_now_ff, pinned_now_in;

   assign stat.req_known = (req_func == lpp_pkg::FUNC_GET) ||
                           (req_func == lpp_pkg::FUNC_PIN) ||
                           (req_func == lpp_pkg::FUNC_UNPIN);

   always_comb begin
      for (int i = 0; i < NF; i++) begin
         hit_vec_in[i]    = frame_valid_ff[i] && (frame_page_ff[i] == page_ff);
         free_vec_in[i]   = !frame_valid_ff[i];
         pinned_vec_in[i] = 1'b0;
         for (int j = 0; j < NS; j++) begin
            if (pin_used_ff[j] && (pin_page_ff[j] == frame_page_ff[i])) begin
               pinned_vec_in[i] = 1'b1;
            end
         end
      end
      for (int j = 0; j < NS; j++) begin
         match_vec_in[j] = pin_used_ff[j] && (pin_page_ff[j] == page_ff);
         open_vec_in[j]  = !pin_used_ff[j];
      end
   end

   always_comb begin
      for (int i = 0; i < NF; i++) begin
         victim_vec[i] = !pinned_vec_ff[i];
         for (int j = 0; j < NF; j++) begin
            if (!pinned_vec_ff[j] && (rank_ff[j] > rank_ff[i])) begin
               victim_vec[i] = 1'b0;
            end
         end
      end
   end

   assign hit_idx    = lpp_pkg::lowest_frame(hit_vec_ff);
   assign free_idx   = lpp_pkg::lowest_frame(free_vec_ff);
   assign victim_idx = lpp_pkg::lowest_frame(victim_vec);
   assign match_idx  = lpp_pkg::lowest_slot(match_vec_ff);
   assign open_idx   = lpp_pkg::lowest_slot(open_vec_ff);

   always_comb begin
      frame_valid_in = frame_valid_ff;
      pin_used_in    = pin_used_ff;
      pin_count_in   = pin_count_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      evicts_in      = evicts_ff;
      fp_we          = 1'b0;
      fp_idx         = '0;
      pp_we          = 1'b0;
      pp_idx         = open_idx;
      promote_en     = 1'b0;
      promote_all    = 1'b0;
      promote_idx    = '0;
      promote_limit  = '0;
      status_in      = status_ff;
      frame_in       = frame_ff;
      evicted_in     = evicted_ff;
      ev_page_in     = ev_page_ff;
      pinned_now_in  = pinned_now_ff;

      if (cmd.apply) begin
         frame_in      = '0;
         evicted_in    = 1'b0;
         ev_page_in    = '0;
         pinned_now_in = |match_vec_ff;
         unique case (func_ff)
            lpp_pkg::FUNC_GET: begin
               if (|hit_vec_ff) begin
                  hits_in       = hits_ff + 1'b1;
                  promote_en    = 1'b1;
                  promote_idx   = hit_idx;
                  promote_limit = rank_ff[hit_idx];
                  status_in     = lpp_pkg::ST_HIT;
                  frame_in      = hit_idx;
               end else begin
                  misses_in = misses_ff + 1'b1;
                  if (|free_vec_ff) begin
                     frame_valid_in[free_idx] = 1'b1;
                     fp_we       = 1'b1;
                     fp_idx      = free_idx;
                     promote_en  = 1'b1;
                     promote_all = 1'b1;
                     promote_idx = free_idx;
                     status_in   = lpp_pkg::ST_MISS;
                     frame_in    = free_idx;
                  end else if (|victim_vec) begin
                     evicts_in     = evicts_ff + 1'b1;
                     evicted_in    = 1'b1;
                     ev_page_in    = frame_page_ff[victim_idx];
                     fp_we         = 1'b1;
                     fp_idx        = victim_idx;
                     promote_en    = 1'b1;
                     promote_idx   = victim_idx;
                     promote_limit = rank_ff[victim_idx];
                     status_in     = lpp_pkg::ST_MISS;
                     frame_in      = victim_idx;
                  end else begin
                     status_in = lpp_pkg::ST_EXHAUSTED;
                  end
               end
            end
            lpp_pkg::FUNC_PIN: begin
               if (|match_vec_ff) begin
                  if (pin_count_ff[match_idx] != lpp_pkg::PIN_MAX) begin
                     pin_count_in[match_idx] = pin_count_ff[match_idx] + 1'b1;
                  end
                  status_in     = lpp_pkg::ST_PIN_DONE;
                  pinned_now_in = 1'b1;
               end else if (|open_vec_ff) begin
                  pin_used_in[open_idx]  = 1'b1;
                  pin_count_in[open_idx] = CW'(1);
                  pp_we         = 1'b1;
                  status_in     = lpp_pkg::ST_PIN_DONE;
                  pinned_now_in = 1'b1;
               end else begin
                  status_in     = lpp_pkg::ST_PIN_FULL;
                  pinned_now_in = 1'b0;
               end
            end
            lpp_pkg::FUNC_UNPIN: begin
               if (|match_vec_ff) begin
                  if (pin_count_ff[match_idx] != '0) begin
                     pin_count_in[match_idx] = pin_count_ff[match_idx] - 1'b1;
                  end
                  if (pin_count_ff[match_idx] <= CW'(1)) begin
                     pin_used_in[match_idx] = 1'b0;
                     pinned_now_in = 1'b0;
                  end else begin
                     pinned_now_in = 1'b1;
                  end
                  status_in = lpp_pkg::ST_PIN_DONE;
               end else begin
                  status_in     = lpp_pkg::ST_UNPIN_BAD;
                  pinned_now_in = 1'b0;
               end
            end
            default: begin
               status_in = status_ff;
            end
         endcase
      end

      rank_in = rank_ff;
      if (promote_en) begin
         for (int i = 0; i < NF; i++) begin
            if (FW'(i) == promote_idx) begin
               rank_in[i] = '0;
            end else if (frame_valid_ff[i] && (promote_all || (rank_ff[i] < promote_limit)))
            begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         pin_used_ff    <= '0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         evicts_ff      <= '0;
         for (int i = 0; i < NF; i++) begin
            rank_ff[i] <= '0;
         end
         for (int j = 0; j < NS; j++) begin
            pin_count_ff[j] <= '0;
         end
      end else begin
         frame_valid_ff <= frame_valid_in;
         pin_used_ff    <= pin_used_in;
         hits_ff        <= hits_in;
         misses_ff      <= misses_in;
         evicts_ff      <= evicts_in;
         rank_ff        <= rank_in;
         pin_count_ff   <= pin_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         page_ff <= req_page;
      end
      if (cmd.look) begin
         hit_vec_ff    <= hit_vec_in;
         free_vec_ff   <= free_vec_in;
         pinned_vec_ff <= pinned_vec_in;
         match_vec_ff  <= match_vec_in;
         open_vec_ff   <= open_vec_in;
      end
      if (fp_we) begin
         frame_page_ff[fp_idx] <= page_ff;
      end
      if (pp_we) begin
         pin_page_ff[pp_idx] <= page_ff;
      end
      status_ff     <= status_in;
      frame_ff      <= frame_in;
      evicted_ff    <= evicted_in;
      ev_page_ff    <= ev_page_in;
      pinned_now_ff <= pinned_now_in;
   end

   assign rsp_status = status_ff;
   assign rsp_data   = {
      (lpp_pkg::RSP_DATA_W - lpp_pkg::RSP_FIELDS_W)'(0),
      evicts_ff,
      misses_ff,
      hits_ff,
      pinned_now_ff,
      ev_page_ff,
      evicted_ff,
      lpp_pkg::FRAME_FIELD_W'(frame_ff)
   };

endmodule

`default_nettype wire

// ===== tb/tb_lru_page_pool_with_pinning.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lru_page_pool_with_pinning: directed script, random traffic
// and a pin-table drain, all scored against a local pool model.
// Depends on lpp_pkg for widths, function codes and status codes.

module tb_lru_page_pool_with_pinning;
   import lpp_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_BEATS = 1300;
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   typedef struct packed {
      status_type         status;
      logic [3:0]         frame;
      logic               evicted;
      logic [PAGE_W-1:0]  evicted_page;
      logic               pinned_now;
      logic [TOTAL_W-1:0] hits;
      logic [TOTAL_W-1:0] misses;
      logic [TOTAL_W-1:0] evicts;
   } pool_rsp_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PAGE_W-1:0] page;
      logic [7:0]        reps;
      logic              typed;
      status_type        st;
      logic [3:0]        frm;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [FUNC_W-1:0]     req_tuser = '0;   // func
   logic [PAGE_W-1:0]     req_tdata = '0;   // page
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [STATUS_W-1:0]   rsp_tuser;        // status
   // frame[3:0], evicted[4], evicted_page[36:5], pinned_now[37],
   // hit_total[69:38], miss_total[101:70], evict_total[133:102], zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   lru_page_pool_with_pinning dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pool model state
   bit                 frame_live [POOL_FRAMES];
   logic [PAGE_W-1:0]  frame_tag  [POOL_FRAMES];
   logic [31:0]        frame_age  [POOL_FRAMES];
   bit                 slot_busy  [PIN_SLOTS];
   logic [PAGE_W-1:0]  slot_tag   [PIN_SLOTS];
   int unsigned        slot_pins  [PIN_SLOTS];
   logic [TOTAL_W-1:0] hit_cnt, miss_cnt, evict_cnt;

   pool_rsp_type pending_rsp [$];
   int        mismatches = 0;
   int        status_seen [8];
   int        dropped_beats = 0;
   int        beats_sent = 0;
   int        cycles = 0;
   bit        gaps_on = 1'b1;
   bit        stalls_on = 1'b1;
   int        stall_left = 0;

   function automatic int pin_slot_of(input logic [PAGE_W-1:0] page);
      for (int i = 0; i < PIN_SLOTS; i++) begin
         if (slot_busy[i] && slot_tag[i] == page) return i;
      end
      return -1;
   endfunction

   // frame f becomes newest; valid frames younger than limit age by one
   function automatic void make_newest(input int f, input logic [31:0] limit);
      for (int i = 0; i < POOL_FRAMES; i++) begin
         if (i != f && frame_live[i] && frame_age[i] < limit) frame_age[i]++;
      end
      frame_age[f] = '0;
   endfunction

   function automatic bit predict_access(input logic [FUNC_W-1:0] func,
                                         input logic [PAGE_W-1:0] page,
                                         output pool_rsp_type r);
      int hit_f, free_f, victim, s, i;
      hit_f = -1;
      free_f = -1;
      victim = -1;
      r = '0;
      if (func == FUNC_GET) begin
         for (i = 0; i < POOL_FRAMES; i++) begin
            if (frame_live[i] && frame_tag[i] == page && hit_f < 0) hit_f = i;
            if (!frame_live[i] && free_f < 0) free_f = i;
         end
         if (hit_f >= 0) begin
            hit_cnt++;
            make_newest(hit_f, frame_age[hit_f]);
            r.status = ST_HIT;
            r.frame = 4'(hit_f);
         end else begin
            miss_cnt++;
            if (free_f >= 0) begin
               frame_live[free_f] = 1'b1;
               frame_tag[free_f] = page;
               make_newest(free_f, 32'hFFFF_FFFF);
               r.status = ST_MISS;
               r.frame = 4'(free_f);
            end else begin
               for (i = 0; i < POOL_FRAMES; i++) begin
                  if (pin_slot_of(frame_tag[i]) >= 0) continue;
                  if (victim < 0 || frame_age[i] > frame_age[victim]) victim = i;
               end
               if (victim < 0) begin
                  r.status = ST_EXHAUSTED;
               end else begin
                  evict_cnt++;
                  r.evicted = 1'b1;
                  r.evicted_page = frame_tag[victim];
                  frame_tag[victim] = page;
                  make_newest(victim, frame_age[victim]);
                  r.status = ST_MISS;
                  r.frame = 4'(victim);
               end
            end
         end
      end else if (func == FUNC_PIN) begin
         s = pin_slot_of(page);
         if (s >= 0) begin
            if (slot_pins[s] < PIN_MAX) slot_pins[s]++;
            r.status = ST_PIN_DONE;
         end else begin
            for (i = 0; i < PIN_SLOTS; i++) begin
               if (!slot_busy[i]) break;
            end
            if (i < PIN_SLOTS) begin
               slot_busy[i] = 1'b1;
               slot_tag[i] = page;
               slot_pins[i] = 1;
               r.status = ST_PIN_DONE;
            end else begin
               r.status = ST_PIN_FULL;
            end
         end
      end else if (func == FUNC_UNPIN) begin
         s = pin_slot_of(page);
         if (s < 0) begin
            r.status = ST_UNPIN_BAD;
         end else begin
            if (slot_pins[s] > 0) slot_pins[s]--;
            if (slot_pins[s] == 0) begin
               slot_busy[s] = 1'b0;
               slot_tag[s] = '0;
            end
            r.status = ST_PIN_DONE;
         end
      end else begin
         return 1'b0;
      end
      r.pinned_now = (pin_slot_of(page) >= 0);
      r.hits = hit_cnt;
      r.misses = miss_cnt;
      r.evicts = evict_cnt;
      return 1'b1;
   endfunction

   // drive one request beat; on acceptance predict and queue its result
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [PAGE_W-1:0] page,
                               input bit typed, input status_type st, input logic [3:0] frm);
      pool_rsp_type r;
      bit        has_rsp;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= page;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      has_rsp = predict_access(func, page, r);
      if (has_rsp) begin
         if (typed) begin
            r.status = st;
            r.frame = frm;
         end
         status_seen[r.status]++;
         pending_rsp.push_back(r);
      end else begin
         dropped_beats++;
      end
   endtask

   function automatic logic [PAGE_W-1:0] hot_page();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return PAGE_W'($urandom_range(0, 23));
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pool_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tuser);
         got.frame = rsp_tdata[3:0];
         got.evicted = rsp_tdata[4];
         got.evicted_page = rsp_tdata[36:5];
         got.pinned_now = rsp_tdata[37];
         got.hits = rsp_tdata[69:38];
         got.misses = rsp_tdata[101:70];
         got.evicts = rsp_tdata[133:102];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result beat with nothing pending: status %0d", $time, rsp_tuser);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want || rsp_tuser !== want.status ||
                rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W] !== '0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0t] mismatch exp: st %0d fr %0d ev %0b evp %h pin %0b",
                           $time, want.status, want.frame, want.evicted, want.evicted_page,
                           want.pinned_now);
                  $display("      exp totals: h %0d m %0d e %0d",
                           want.hits, want.misses, want.evicts);
                  $display("[%0t]          act: st %0d fr %0d ev %0b evp %h pin %0b",
                           $time, rsp_tuser, got.frame, got.evicted, got.evicted_page,
                           got.pinned_now);
                  $display("      act totals: h %0d m %0d e %0d pad %h",
                           got.hits, got.misses, got.evicts,
                           rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_rsp.size());
         $display("FAILURE");
         $finish;
      end
   end

   script_row_type script [17] = '{
      '{FUNC_GET,   32'h0000_0000, 8'd1, 1'b1, ST_MISS,      4'd0},
      '{FUNC_GET,   32'h0000_0000, 8'd1, 1'b1, ST_HIT,       4'd0},
      '{FUNC_GET,   32'hFFFF_FFFF, 8'd1, 1'b1, ST_MISS,      4'd1},
      '{FUNC_PIN,   32'h0000_0001, 8'd1, 1'b1, ST_PIN_DONE,  4'd0},
      '{FUNC_PIN,   32'h0000_0001, 8'd1, 1'b1, ST_PIN_DONE,  4'd0},
      '{FUNC_PIN,   32'hFFFF_FFFF, 8'd1, 1'b1, ST_PIN_DONE,  4'd0},
      '{FUNC_UNPIN, 32'h0000_0001, 8'd1, 1'b1, ST_PIN_DONE,  4'd0},
      '{FUNC_UNPIN, 32'h0000_0001, 8'd1, 1'b1, ST_PIN_DONE,  4'd0},
      '{FUNC_UNPIN, 32'h0000_0001, 8'd1, 1'b1, ST_UNPIN_BAD, 4'd0},
      '{FUNC_UNPIN, 32'h0000_0000, 8'd1, 1'b1, ST_UNPIN_BAD, 4'd0},
      '{FUNC_NONE,  32'h5A5A_A5A5, 8'd1, 1'b0, ST_HIT,       4'd0},
      '{FUNC_PIN,   32'h0000_0002, 8'd7, 1'b1, ST_PIN_DONE,  4'd0},
      '{FUNC_PIN,   32'h0000_0009, 8'd1, 1'b1, ST_PIN_FULL,  4'd0},
      '{FUNC_UNPIN, 32'h0000_0005, 8'd1, 1'b0, ST_HIT,       4'd0},
      '{FUNC_PIN,   32'h0000_0009, 8'd1, 1'b0, ST_HIT,       4'd0},
      '{FUNC_GET,   32'h0000_0009, 8'd1, 1'b1, ST_MISS,      4'd2},
      '{FUNC_GET,   32'hFFFF_FFFF, 8'd1, 1'b1, ST_HIT,       4'd1}
   };

   initial begin
      int               pick, slot;
      int               busy_slots [$];
      logic [FUNC_W-1:0] fn;
      logic [PAGE_W-1:0] pg;

      for (int i = 0; i < POOL_FRAMES; i++) begin
         frame_live[i] = 1'b0;
         frame_tag[i] = '0;
         frame_age[i] = '0;
      end
      for (int i = 0; i < PIN_SLOTS; i++) begin
         slot_busy[i] = 1'b0;
         slot_tag[i] = '0;
         slot_pins[i] = 0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed script; rows with several repeats walk consecutive pages
      foreach (script[r]) begin
         for (int k = 0; k < script[r].reps; k++)
            send_request(script[r].func, script[r].page + PAGE_W'(k), script[r].typed,
                         script[r].st, script[r].frm);
      end

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         gaps_on = ((n / 200) % 4) != 3;
         stalls_on = gaps_on;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            fn = FUNC_GET;
            pg = hot_page();
         end else if (pick < 70) begin
            fn = FUNC_PIN;
            pg = hot_page();
         end else if (pick < 85) begin
            fn = FUNC_UNPIN;
            busy_slots = {};
            for (int i = 0; i < PIN_SLOTS; i++) if (slot_busy[i]) busy_slots.push_back(i);
            if (busy_slots.size() != 0 && $urandom_range(0, 3) != 0)
               pg = slot_tag[busy_slots[$urandom_range(0, busy_slots.size() - 1)]];
            else
               pg = hot_page();
         end else if (pick < 90) begin
            fn = FUNC_GET;
            pg = $urandom();
         end else if (pick < 95) begin
            fn = $urandom_range(0, 1) ? FUNC_PIN : FUNC_UNPIN;
            pg = $urandom();
         end else begin
            fn = FUNC_NONE;
            pg = $urandom();
         end
         send_request(fn, pg, 1'b0, ST_HIT, 4'd0);
      end

      // last stretch at full rate: release every pin
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      slot = 0;
      while (slot < PIN_SLOTS) begin
         if (slot_busy[slot]) send_request(FUNC_UNPIN, slot_tag[slot], 1'b0, ST_HIT, 4'd0);
         else slot++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d request beats (%0d func-3 drops): hit %0d, miss %0d, exhausted %0d",
               beats_sent, dropped_beats, status_seen[ST_HIT], status_seen[ST_MISS],
               status_seen[ST_EXHAUSTED]);
      $display("pin table full %0d, bad unpin %0d, pin/unpin done %0d, evictions %0d",
               status_seen[ST_PIN_FULL], status_seen[ST_UNPIN_BAD], status_seen[ST_PIN_DONE],
               evict_cnt);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d result mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
